[rtl/wmme_pkg.sv]
// ----------------------------------------------------------------------------
// wmme_pkg
// shared types and constants for the min/max waveform envelope block
// ----------------------------------------------------------------------------
package wmme_pkg;

    // register field widths
    localparam int NUM_SAMPLES_W   = 24;
    localparam int BUCKET_COUNT_W  = 13;
    localparam int CHANNEL_COUNT_W = 4;

    // stream payload widths
    localparam int SAMPLE_W = 16;
    localparam int INDEX_W  = 12;
    localparam int MIN_W    = 17;
    localparam int MAX_W    = 16;

    // register map, word index taken from paddr[3:2]
    localparam int          PADDR_W           = 4;
    localparam logic [1:0]  REG_NUM_SAMPLES   = 2'd0;
    localparam logic [1:0]  REG_BUCKET_COUNT  = 2'd1;
    localparam logic [1:0]  REG_CHANNEL_COUNT = 2'd2;

    // running extremes at the start of a bucket (+1.0 and -1.0)
    localparam logic signed [MIN_W-1:0] MIN_START = 17'sd32768;
    localparam logic signed [MAX_W-1:0] MAX_START = -16'sd32768;

    // sample queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_TAIL
    } back_state_t;

    typedef struct packed {
        logic                     last;
        logic                     empty;
        logic signed [MAX_W-1:0]  max;
        logic signed [MIN_W-1:0]  min;
        logic [INDEX_W-1:0]       index;
    } result_t;

endpackage

[rtl/waveform_min_max_envelope.sv]
// ----------------------------------------------------------------------------
// waveform_min_max_envelope
// min/max peak envelope of channel 0 of an interleaved Q1.15 stream
// ----------------------------------------------------------------------------
// The front accepts a beat whenever the queue has room; beats at channel
// positions other than 0 are dropped there. Channel-0 samples pass through a
// four-deep queue to the bucket engine. While the queue keeps it fed, the
// engine loads the next sample as soon as it has folded in the previous one;
// when the queue has run dry it goes idle and wakes when a sample arrives.
// Each bucket that a sample closes is emitted before the sample is folded in.
// After the last sample of a frame the engine emits the remaining buckets,
// restarts the frame and then wakes from idle for the next sample. Bucket
// bounds come from exact running sums, and frame length times bucket count is
// a registered 24 by 13 bit product. Results leave through a single output
// register, so a stalled m_ side holds the engine when it has a bucket to
// emit, while the queue keeps taking beats until it fills. Any register write
// restarts the frame and the interleave position.
// ----------------------------------------------------------------------------
module waveform_min_max_envelope #(
    parameter int MAX_BUCKETS       = 4096,
    parameter int SAMPLE_COUNT_BITS = 24,
    parameter int MAX_CHANNELS      = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // apb configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wmme_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [15:0]                   s_tdata,   // [15:0] sample
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [47:0]                   m_tdata,   // [11:0] bucket_index, [28:12] bucket_min,
                                                     // [44:29] bucket_max, [47:45] zero
    output logic                          m_tuser,   // [0] bucket_empty
    output logic                          m_tlast    // last_bucket
);

    localparam int WB    = $clog2(MAX_BUCKETS + 1);
    localparam int NB    = (SAMPLE_COUNT_BITS < wmme_pkg::NUM_SAMPLES_W) ?
                           SAMPLE_COUNT_BITS : wmme_pkg::NUM_SAMPLES_W;
    localparam int SUM_W = wmme_pkg::NUM_SAMPLES_W + WB;
    localparam int CPW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CCW   = $clog2(MAX_CHANNELS + 1);
    localparam logic [wmme_pkg::NUM_SAMPLES_W-1:0] N_MASK =
        wmme_pkg::NUM_SAMPLES_W'((64'd1 << NB) - 64'd1);

    logic [wmme_pkg::NUM_SAMPLES_W-1:0]   num_samples_reg;
    logic [wmme_pkg::BUCKET_COUNT_W-1:0]  bucket_count_reg;
    logic [wmme_pkg::CHANNEL_COUNT_W-1:0] channel_count_reg;
    logic                                 restart_reg;
    logic [SUM_W-1:0]                     nw_reg;

    logic                                 cfg_write;
    logic                                 cfg_hit;
    logic [wmme_pkg::NUM_SAMPLES_W-1:0]   n_masked;
    logic [wmme_pkg::NUM_SAMPLES_W-1:0]   eff_n;
    logic [31:0]                          w32;
    logic [31:0]                          lim32;
    logic [31:0]                          c32;
    logic [WB-1:0]                        eff_w;
    logic [CCW-1:0]                       eff_c;

    logic                                 push;
    logic [wmme_pkg::SAMPLE_W-1:0]        push_data;
    logic                                 pop;
    logic [wmme_pkg::SAMPLE_W-1:0]        pop_data;
    logic                                 fifo_empty;
    logic                                 fifo_full;
    logic                                 out_valid;
    wmme_pkg::result_t                    out_beat;

    // ---------------- configuration port ----------------

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_hit   = cfg_write && ((paddr[3:2] == wmme_pkg::REG_NUM_SAMPLES) ||
                                     (paddr[3:2] == wmme_pkg::REG_BUCKET_COUNT) ||
                                     (paddr[3:2] == wmme_pkg::REG_CHANNEL_COUNT));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_samples_reg   <= wmme_pkg::NUM_SAMPLES_W'(1);
            bucket_count_reg  <= wmme_pkg::BUCKET_COUNT_W'(1500);
            channel_count_reg <= wmme_pkg::CHANNEL_COUNT_W'(1);
            restart_reg       <= 1'b0;
        end else begin
            // engine restarts in the cycle after the write, once the new values are in place
            restart_reg <= cfg_hit;
            if (cfg_write) begin
                unique case (paddr[3:2])
                    wmme_pkg::REG_NUM_SAMPLES:
                        num_samples_reg <= pwdata[wmme_pkg::NUM_SAMPLES_W-1:0];
                    wmme_pkg::REG_BUCKET_COUNT:
                        bucket_count_reg <= pwdata[wmme_pkg::BUCKET_COUNT_W-1:0];
                    wmme_pkg::REG_CHANNEL_COUNT:
                        channel_count_reg <= pwdata[wmme_pkg::CHANNEL_COUNT_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            wmme_pkg::REG_NUM_SAMPLES:   prdata = 32'(num_samples_reg);
            wmme_pkg::REG_BUCKET_COUNT:  prdata = 32'(bucket_count_reg);
            wmme_pkg::REG_CHANNEL_COUNT: prdata = 32'(channel_count_reg);
            default:                     prdata = '0;
        endcase
    end

    // ---------------- effective frame settings ----------------

    always_comb begin
        n_masked = num_samples_reg & N_MASK;
        eff_n    = (n_masked == '0) ? wmme_pkg::NUM_SAMPLES_W'(1) : n_masked;

        // at most 32 buckets per sample
        lim32 = {3'b000, eff_n, 5'b00000};
        w32   = 32'(bucket_count_reg);
        if (w32 == 32'd0) begin
            w32 = 32'd1;
        end
        if (w32 > 32'(MAX_BUCKETS)) begin
            w32 = 32'(MAX_BUCKETS);
        end
        if (w32 > lim32) begin
            w32 = lim32;
        end
        eff_w = WB'(w32);

        c32 = 32'(channel_count_reg);
        if (c32 == 32'd0) begin
            c32 = 32'd1;
        end
        if (c32 > 32'(MAX_CHANNELS)) begin
            c32 = 32'(MAX_CHANNELS);
        end
        eff_c = CCW'(c32);
    end

    // frame end threshold n*w
    always_ff @(posedge aclk) begin
        nw_reg <= SUM_W'(eff_n) * SUM_W'(eff_w);
    end

    // ---------------- datapath ----------------

    wmme_front #(
        .CPW (CPW),
        .CCW (CCW)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_write (cfg_hit),
        .eff_c     (eff_c),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .fifo_full (fifo_full),
        .push      (push),
        .push_data (push_data)
    );

    wmme_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (fifo_empty),
        .full      (fifo_full)
    );

    wmme_back #(
        .WB    (WB),
        .SUM_W (SUM_W)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .restart    (restart_reg),
        .eff_n      (eff_n),
        .eff_w      (eff_w),
        .nw         (nw_reg),
        .fifo_empty (fifo_empty),
        .fifo_data  (pop_data),
        .pop        (pop),
        .m_ready    (m_tready),
        .out_valid  (out_valid),
        .out_beat   (out_beat)
    );

    assign m_tvalid = out_valid;
    assign m_tdata  = {3'b000, out_beat.max, out_beat.min, out_beat.index};
    assign m_tuser  = out_beat.empty;
    assign m_tlast  = out_beat.last;

    // ---------------- assertions ----------------

    // the frame closes on the highest bucket index in use
    a_last_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[11:0] == wmme_pkg::INDEX_W'(eff_w - 1'b1))
        else $error("last bucket carries wrong index");

    // a bucket with samples never reports min above max
    a_min_le_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |->
            $signed(m_tdata[28:12]) <= $signed({m_tdata[44], m_tdata[44:29]}))
        else $error("bucket min above bucket max");

    // an empty bucket reports the start values untouched
    a_empty_start: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |->
            m_tdata[28:12] == wmme_pkg::MIN_START && m_tdata[44:29] == wmme_pkg::MAX_START)
        else $error("empty bucket with modified extremes");

endmodule

[rtl/wmme_front.sv]
// ----------------------------------------------------------------------------
// wmme_front
// input side: tracks the interleave position and forwards channel 0 only
// ----------------------------------------------------------------------------
module wmme_front #(
    parameter int CPW = 3,
    parameter int CCW = 4
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_write,
    input  logic [CCW-1:0]                 eff_c,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [wmme_pkg::SAMPLE_W-1:0]  s_tdata,
    input  logic                           fifo_full,
    output logic                           push,
    output logic [wmme_pkg::SAMPLE_W-1:0]  push_data
);

    logic [CPW-1:0] pos_reg;
    logic [CPW-1:0] pos_next;
    logic           accept;

    assign s_tready  = !fifo_full;
    assign accept    = s_tvalid && s_tready;
    assign push      = accept && (pos_reg == '0);
    assign push_data = s_tdata;

    always_comb begin
        pos_next = pos_reg;
        if (cfg_write) begin
            pos_next = '0;
        end else if (accept) begin
            if ((32'(pos_reg) + 32'd1) >= 32'(eff_c)) begin
                pos_next = '0;
            end else begin
                pos_next = CPW'(32'(pos_reg) + 32'd1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else begin
            pos_reg <= pos_next;
        end
    end

endmodule

[rtl/wmme_fifo.sv]
// ----------------------------------------------------------------------------
// wmme_fifo
// short sample queue that decouples the front from the bucket engine
// ----------------------------------------------------------------------------
module wmme_fifo (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           push,
    input  logic [wmme_pkg::SAMPLE_W-1:0]  push_data,
    input  logic                           pop,
    output logic [wmme_pkg::SAMPLE_W-1:0]  pop_data,
    output logic                           empty,
    output logic                           full
);

    logic [wmme_pkg::SAMPLE_W-1:0] mem [wmme_pkg::FIFO_DEPTH];
    logic [wmme_pkg::FIFO_AW-1:0]  wr_ptr_reg;
    logic [wmme_pkg::FIFO_AW-1:0]  rd_ptr_reg;
    logic [wmme_pkg::FIFO_AW:0]    count_reg;
    logic                          do_push;
    logic                          do_pop;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == (wmme_pkg::FIFO_AW+1)'(wmme_pkg::FIFO_DEPTH));
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

[rtl/wmme_back.sv]
// ----------------------------------------------------------------------------
// wmme_back
// bucket engine: boundary tracking with running sums, min/max, result register
// ----------------------------------------------------------------------------
module wmme_back #(
    parameter int WB    = 13,
    parameter int SUM_W = 37
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  restart,
    input  logic [wmme_pkg::NUM_SAMPLES_W-1:0]    eff_n,
    input  logic [WB-1:0]                         eff_w,
    input  logic [SUM_W-1:0]                      nw,
    input  logic                                  fifo_empty,
    input  logic [wmme_pkg::SAMPLE_W-1:0]         fifo_data,
    output logic                                  pop,
    input  logic                                  m_ready,
    output logic                                  out_valid,
    output wmme_pkg::result_t                     out_beat
);

    wmme_pkg::back_state_t state_reg, state_next;

    logic signed [wmme_pkg::SAMPLE_W-1:0] sample_reg, sample_next;
    logic [SUM_W-1:0]                     sample_sum_reg, sample_sum_next;
    logic [SUM_W-1:0]                     bucket_sum_reg, bucket_sum_next;
    logic [WB-1:0]                        cur_reg, cur_next;
    logic signed [wmme_pkg::MIN_W-1:0]    min_reg, min_next;
    logic signed [wmme_pkg::MAX_W-1:0]    max_reg, max_next;
    logic                                 seen_reg, seen_next;
    logic                                 out_valid_reg, out_valid_next;
    wmme_pkg::result_t                    out_reg, out_next;

    logic                                 out_free;
    logic                                 more_closed;
    logic                                 is_last;
    logic                                 do_emit;
    logic                                 emit_last;
    logic                                 do_load;
    logic signed [wmme_pkg::MIN_W-1:0]    sample_ext;

    assign out_free    = !out_valid_reg || m_ready;
    assign more_closed = (bucket_sum_reg < sample_sum_reg) &&
                         (({1'b0, cur_reg} + 1'b1) < {1'b0, eff_w});
    assign is_last     = (({1'b0, cur_reg} + 1'b1) == {1'b0, eff_w});
    assign sample_ext  = {sample_reg[wmme_pkg::SAMPLE_W-1], sample_reg};
    assign pop         = do_load;
    assign out_valid   = out_valid_reg;
    assign out_beat    = out_reg;

    always_comb begin
        state_next      = state_reg;
        sample_next     = sample_reg;
        sample_sum_next = sample_sum_reg;
        bucket_sum_next = bucket_sum_reg;
        cur_next        = cur_reg;
        min_next        = min_reg;
        max_next        = max_reg;
        seen_next       = seen_reg;
        out_valid_next  = m_ready ? 1'b0 : out_valid_reg;
        out_next        = out_reg;
        do_emit         = 1'b0;
        emit_last       = 1'b0;
        do_load         = 1'b0;

        if (restart) begin
            state_next      = wmme_pkg::BK_IDLE;
            sample_sum_next = '0;
            bucket_sum_next = SUM_W'(eff_n);
            cur_next        = '0;
            min_next        = wmme_pkg::MIN_START;
            max_next        = wmme_pkg::MAX_START;
            seen_next       = 1'b0;
        end else begin
            unique case (state_reg)
                wmme_pkg::BK_IDLE: begin
                    if (!fifo_empty) begin
                        do_load    = 1'b1;
                        state_next = wmme_pkg::BK_SCAN;
                    end
                end
                wmme_pkg::BK_SCAN: begin
                    if (more_closed) begin
                        // buckets ending before this sample go out first
                        do_emit = out_free;
                    end else begin
                        if (sample_ext < min_reg) begin
                            min_next = sample_ext;
                        end
                        if (sample_reg > max_reg) begin
                            max_next = sample_reg;
                        end
                        seen_next = 1'b1;
                        if (sample_sum_reg >= nw) begin
                            state_next = wmme_pkg::BK_TAIL;
                        end else if (!fifo_empty) begin
                            do_load = 1'b1;
                        end else begin
                            state_next = wmme_pkg::BK_IDLE;
                        end
                    end
                end
                wmme_pkg::BK_TAIL: begin
                    if (cur_reg < eff_w) begin
                        do_emit   = out_free;
                        emit_last = is_last;
                    end else begin
                        state_next      = wmme_pkg::BK_IDLE;
                        sample_sum_next = '0;
                        bucket_sum_next = SUM_W'(eff_n);
                        cur_next        = '0;
                        min_next        = wmme_pkg::MIN_START;
                        max_next        = wmme_pkg::MAX_START;
                        seen_next       = 1'b0;
                    end
                end
                default: begin
                    state_next = wmme_pkg::BK_IDLE;
                end
            endcase
        end

        if (do_load) begin
            sample_next     = fifo_data;
            sample_sum_next = sample_sum_reg + SUM_W'(eff_w);
        end

        if (do_emit) begin
            out_valid_next  = 1'b1;
            out_next.index  = wmme_pkg::INDEX_W'(cur_reg);
            out_next.min    = min_reg;
            out_next.max    = max_reg;
            out_next.empty  = !seen_reg;
            out_next.last   = emit_last;
            cur_next        = cur_reg + 1'b1;
            bucket_sum_next = bucket_sum_reg + SUM_W'(eff_n);
            min_next        = wmme_pkg::MIN_START;
            max_next        = wmme_pkg::MAX_START;
            seen_next       = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= wmme_pkg::BK_IDLE;
            sample_sum_reg <= '0;
            bucket_sum_reg <= SUM_W'(1);
            cur_reg        <= '0;
            min_reg        <= wmme_pkg::MIN_START;
            max_reg        <= wmme_pkg::MAX_START;
            seen_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            sample_sum_reg <= sample_sum_next;
            bucket_sum_reg <= bucket_sum_next;
            cur_reg        <= cur_next;
            min_reg        <= min_next;
            max_reg        <= max_next;
            seen_reg       <= seen_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sample_reg <= sample_next;
        out_reg    <= out_next;
    end

endmodule
